// ===== rtl/scbpa_pkg.sv =====
// shared types, register map and status codes of the size-class block pool allocator
package scbpa_pkg;

	localparam int CFG_CLASSES = 4;
	localparam int PADDR_W     = 5;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_LINK  = 2'd2;

	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_ZERO_SIZE  = 3'd1;
	localparam logic [2:0] STS_TOO_LARGE  = 3'd2;
	localparam logic [2:0] STS_EXHAUSTED  = 3'd3;
	localparam logic [2:0] STS_INVALID    = 3'd4;
	localparam logic [2:0] STS_UNUSED     = 3'd5;
	localparam logic [2:0] STS_LINK_LIMIT = 3'd6;

	localparam logic [2:0] REG_SIZE0  = 3'd0;
	localparam logic [2:0] REG_SIZE1  = 3'd1;
	localparam logic [2:0] REG_SIZE2  = 3'd2;
	localparam logic [2:0] REG_SIZE3  = 3'd3;
	localparam logic [2:0] REG_COUNT0 = 3'd4;
	localparam logic [2:0] REG_COUNT1 = 3'd5;
	localparam logic [2:0] REG_COUNT2 = 3'd6;
	localparam logic [2:0] REG_COUNT3 = 3'd7;

	typedef struct packed {
		logic [CFG_CLASSES-1:0][15:0] size;
		logic [CFG_CLASSES-1:0][8:0]  count;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		size:  {16'd4096, 16'd1024, 16'd256, 16'd64},
		count: {9'd256, 9'd256, 9'd256, 9'd256}
	};

endpackage

// ===== rtl/size_class_block_pool_allocator.sv =====
// top level: size-class block pool allocator
// done is registered from the EXEC state; one result per request
// a new request is taken only while busy is low; busy is high for the one cycle in which
// the reference-count and free-stack words read at accept are modified and written back
// reset: takes effect at once, no clearing pass; a reference count at or above a
// class's fresh pointer reads as zero; results cannot be stalled by the receiver
module size_class_block_pool_allocator #(
	parameter int NUM_CLASSES = 4,
	parameter int MAX_BLOCKS  = 256,
	parameter int MAX_REFS    = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scbpa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [15:0]                   req_size,
	input  logic                          handle_null,
	input  logic [1:0]                    handle_class,
	input  logic [7:0]                    handle_slot,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [1:0]                    grant_class,
	output logic [7:0]                    grant_slot,
	output logic [3:0]                    ref_count
);

	localparam int NC    = (NUM_CLASSES < scbpa_pkg::CFG_CLASSES) ? NUM_CLASSES
		: scbpa_pkg::CFG_CLASSES;
	localparam int CLW   = (NC > 1) ? $clog2(NC) : 1;
	localparam int SW    = $clog2(MAX_BLOCKS);
	localparam int CW    = $clog2(MAX_BLOCKS + 1);
	localparam int RW    = $clog2(MAX_REFS + 1);
	localparam int DEPTH = NC * (1 << SW);
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	scbpa_pkg::cfg_t cfg;

	state_t                       state_q;
	logic [NC-1:0][CW-1:0]        depth_q;
	logic [NC-1:0][CW-1:0]        fresh_q;
	logic                         done_q;
	logic [2:0]                   status_q;
	logic [1:0]                   grant_class_q;
	logic [7:0]                   grant_slot_q;
	logic [3:0]                   ref_count_q;

	logic [RW-1:0]                refs_mem [DEPTH];
	logic [SW-1:0]                stack_mem [DEPTH];
	logic [RW-1:0]                refs_rd_s1;
	logic [SW-1:0]                stack_rd_s1;

	logic [1:0]                   type_s1;
	logic [2:0]                   status_s1;
	logic [1:0]                   cls_s1;
	logic [SW-1:0]                slot_s1;
	logic                         pop_s1;
	logic                         valid_s1;

	logic                         accept;
	logic                         prefix;
	logic [scbpa_pkg::CFG_CLASSES-1:0]         active;
	logic [scbpa_pkg::CFG_CLASSES-1:0][CW-1:0] eff;
	logic [15:0]                  last_size;
	logic                         found;
	logic [1:0]                   sel_c;
	logic                         sel_pop;
	logic [SW-1:0]                sel_fresh;
	logic [AW-1:0]                stack_raddr;
	logic [AW-1:0]                refs_raddr;
	logic [CW-1:0]                h_fresh;
	logic                         h_ok;
	logic                         h_valid;
	logic [2:0]                   acc_status;

	logic [RW-1:0]                r;
	logic [CW-1:0]                s1_depth;
	logic [SW-1:0]                alloc_slot;
	logic                         refs_we;
	logic [AW-1:0]                refs_waddr;
	logic [RW-1:0]                refs_wdata;
	logic                         push;
	logic [AW-1:0]                push_addr;
	logic [2:0]                   ex_status;
	logic [1:0]                   ex_gc;
	logic [7:0]                   ex_gs;
	logic [3:0]                   ex_rc;

	scbpa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy        = (state_q == ST_EXEC);
	assign accept      = start && !busy;
	assign done        = done_q;
	assign status      = status_q;
	assign grant_class = grant_class_q;
	assign grant_slot  = grant_slot_q;
	assign ref_count   = ref_count_q;
	assign refs_raddr  = AW'({CLW'(handle_class), SW'(handle_slot)});

	// class decode and request check at accept
	always_comb begin
		prefix      = 1'b1;
		last_size   = 16'd0;
		found       = 1'b0;
		sel_c       = 2'd0;
		sel_pop     = 1'b0;
		sel_fresh   = '0;
		stack_raddr = '0;
		h_fresh     = '0;
		for (int c = 0; c < scbpa_pkg::CFG_CLASSES; c++) begin
			prefix    = prefix && (c < NUM_CLASSES) && (cfg.size[c] != 16'd0)
				&& (cfg.count[c] != 9'd0);
			active[c] = prefix;
			eff[c]    = (32'(cfg.count[c]) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(cfg.count[c]);
			if (prefix) begin
				last_size = cfg.size[c];
			end
		end
		for (int c = NC - 1; c >= 0; c--) begin
			if (active[c] && cfg.size[c] >= req_size
					&& (depth_q[c] != '0 || fresh_q[c] < eff[c])) begin
				found       = 1'b1;
				sel_c       = 2'(c);
				sel_pop     = (depth_q[c] != '0);
				sel_fresh   = SW'(fresh_q[c]);
				stack_raddr = AW'({CLW'(c), SW'(depth_q[c] - CW'(1))});
			end
		end
		for (int c = 0; c < NC; c++) begin
			if (2'(c) == handle_class) begin
				h_fresh = fresh_q[c];
			end
		end
		h_ok    = (req_type == scbpa_pkg::REQ_FREE || req_type == scbpa_pkg::REQ_LINK)
			&& !handle_null && active[handle_class]
			&& (32'(handle_slot) < 32'(eff[handle_class]));
		h_valid = 32'(handle_slot) < 32'(h_fresh);
		if (req_type == scbpa_pkg::REQ_ALLOC) begin
			if (req_size == 16'd0) begin
				acc_status = scbpa_pkg::STS_ZERO_SIZE;
			end else if (!active[0] || req_size > last_size) begin
				acc_status = scbpa_pkg::STS_TOO_LARGE;
			end else if (!found) begin
				acc_status = scbpa_pkg::STS_EXHAUSTED;
			end else begin
				acc_status = scbpa_pkg::STS_OK;
			end
		end else begin
			acc_status = h_ok ? scbpa_pkg::STS_OK : scbpa_pkg::STS_INVALID;
		end
	end

	// read-modify-write stage
	always_comb begin
		r          = valid_s1 ? refs_rd_s1 : '0;
		s1_depth   = '0;
		alloc_slot = pop_s1 ? stack_rd_s1 : slot_s1;
		refs_we    = 1'b0;
		refs_waddr = AW'({CLW'(cls_s1), slot_s1});
		refs_wdata = '0;
		push       = 1'b0;
		ex_status  = status_s1;
		ex_gc      = 2'd0;
		ex_gs      = 8'd0;
		ex_rc      = 4'd0;
		for (int c = 0; c < NC; c++) begin
			if (2'(c) == cls_s1) begin
				s1_depth = depth_q[c];
			end
		end
		push_addr = AW'({CLW'(cls_s1), SW'(s1_depth)});
		if (status_s1 == scbpa_pkg::STS_OK) begin
			case (type_s1)
				scbpa_pkg::REQ_ALLOC: begin
					refs_we    = 1'b1;
					refs_waddr = AW'({CLW'(cls_s1), alloc_slot});
					refs_wdata = RW'(1);
					ex_gc      = cls_s1;
					ex_gs      = 8'(alloc_slot);
					ex_rc      = 4'd1;
				end
				scbpa_pkg::REQ_FREE: begin
					if (r == '0) begin
						ex_status = scbpa_pkg::STS_UNUSED;
					end else begin
						refs_we    = 1'b1;
						refs_wdata = RW'(r - RW'(1));
						ex_rc      = 4'(RW'(r - RW'(1)));
						push       = (r == RW'(1)) && (32'(s1_depth) < MAX_BLOCKS);
					end
				end
				scbpa_pkg::REQ_LINK: begin
					if (r == '0) begin
						ex_status = scbpa_pkg::STS_UNUSED;
					end else if (32'(r) >= MAX_REFS) begin
						ex_status = scbpa_pkg::STS_LINK_LIMIT;
						ex_rc     = 4'(r);
					end else begin
						refs_we    = 1'b1;
						refs_wdata = RW'(r + RW'(1));
						ex_rc      = 4'(RW'(r + RW'(1)));
					end
				end
				default: ex_status = scbpa_pkg::STS_INVALID;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			fresh_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						if (req_type == scbpa_pkg::REQ_ALLOC && acc_status == scbpa_pkg::STS_OK) begin
							for (int c = 0; c < NC; c++) begin
								if (2'(c) == sel_c) begin
									if (sel_pop) begin
										depth_q[c] <= depth_q[c] - CW'(1);
									end else begin
										fresh_q[c] <= fresh_q[c] + CW'(1);
									end
								end
							end
						end
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (push) begin
						for (int c = 0; c < NC; c++) begin
							if (2'(c) == cls_s1) begin
								depth_q[c] <= depth_q[c] + CW'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1   <= req_type;
			status_s1 <= acc_status;
			cls_s1    <= (req_type == scbpa_pkg::REQ_ALLOC) ? sel_c : handle_class;
			slot_s1   <= (req_type == scbpa_pkg::REQ_ALLOC) ? sel_fresh : SW'(handle_slot);
			pop_s1    <= sel_pop;
			valid_s1  <= h_valid;
		end
		if (state_q == ST_EXEC) begin
			status_q      <= ex_status;
			grant_class_q <= ex_gc;
			grant_slot_q  <= ex_gs;
			ref_count_q   <= ex_rc;
		end
	end

	// reference counts
	always_ff @(posedge clk) begin
		if (refs_we && state_q == ST_EXEC) begin
			refs_mem[refs_waddr] <= refs_wdata;
		end
		if (accept) begin
			refs_rd_s1 <= refs_mem[refs_raddr];
		end
	end

	// freed-slot stacks
	always_ff @(posedge clk) begin
		if (push && state_q == ST_EXEC) begin
			stack_mem[push_addr] <= slot_s1;
		end
		if (accept) begin
			stack_rd_s1 <= stack_mem[stack_raddr];
		end
	end

endmodule

// ===== rtl/scbpa_regs.sv =====
// configuration register file with apb-style access
module scbpa_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scbpa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output scbpa_pkg::cfg_t               cfg
);

	scbpa_pkg::cfg_t cfg_q;
	logic [2:0]      idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= scbpa_pkg::CFG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				scbpa_pkg::REG_SIZE0:  cfg_q.size[0]  <= pwdata[15:0];
				scbpa_pkg::REG_SIZE1:  cfg_q.size[1]  <= pwdata[15:0];
				scbpa_pkg::REG_SIZE2:  cfg_q.size[2]  <= pwdata[15:0];
				scbpa_pkg::REG_SIZE3:  cfg_q.size[3]  <= pwdata[15:0];
				scbpa_pkg::REG_COUNT0: cfg_q.count[0] <= pwdata[8:0];
				scbpa_pkg::REG_COUNT1: cfg_q.count[1] <= pwdata[8:0];
				scbpa_pkg::REG_COUNT2: cfg_q.count[2] <= pwdata[8:0];
				scbpa_pkg::REG_COUNT3: cfg_q.count[3] <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			scbpa_pkg::REG_SIZE0:  prdata = {16'd0, cfg_q.size[0]};
			scbpa_pkg::REG_SIZE1:  prdata = {16'd0, cfg_q.size[1]};
			scbpa_pkg::REG_SIZE2:  prdata = {16'd0, cfg_q.size[2]};
			scbpa_pkg::REG_SIZE3:  prdata = {16'd0, cfg_q.size[3]};
			scbpa_pkg::REG_COUNT0: prdata = {23'd0, cfg_q.count[0]};
			scbpa_pkg::REG_COUNT1: prdata = {23'd0, cfg_q.count[1]};
			scbpa_pkg::REG_COUNT2: prdata = {23'd0, cfg_q.count[2]};
			scbpa_pkg::REG_COUNT3: prdata = {23'd0, cfg_q.count[3]};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the size-class block pool allocator: directed and random requests
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int NCLS     = 4;
	localparam int NBLK     = 256;
	localparam int REF_MAX  = 15;
	localparam int WDOG_MAX = 2000;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] grant_class;
		logic [7:0] grant_slot;
		logic [3:0] ref_count;
	} reply_t;

	class pool_tracker;
		bit [15:0] class_bytes[NCLS];
		bit [8:0]  blk_count[NCLS];
		bit [3:0]  refs[NCLS][NBLK];
		bit [7:0]  freed_stack[NCLS][NBLK];
		int        freed_depth[NCLS];
		int        fresh_next[NCLS];
		reply_t    awaited[$];
		int        mismatches;
		bit        have_grant;
		bit [1:0]  last_class;
		bit [7:0]  last_slot;

		function new();
			for (int c = 0; c < NCLS; c++) begin
				class_bytes[c] = 16'd64 << (2 * c);
				blk_count[c]   = 9'd256;
				freed_depth[c] = 0;
				fresh_next[c]  = 0;
				for (int s = 0; s < NBLK; s++) begin
					refs[c][s]        = 4'd0;
					freed_stack[c][s] = 8'd0;
				end
			end
			mismatches = 0;
			have_grant = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			if (idx <= scbpa_pkg::REG_SIZE3)
				class_bytes[idx] = val[15:0];
			else
				blk_count[idx - scbpa_pkg::REG_COUNT0] = val[8:0];
		endfunction

		function int active_classes();
			int n;
			n = 0;
			while (n < NCLS && class_bytes[n] != 0 && blk_count[n] != 0)
				n++;
			return n;
		endfunction

		function int usable_blocks(int c);
			return (blk_count[c] > NBLK) ? NBLK : int'(blk_count[c]);
		endfunction

		function reply_t predict_reply(logic [1:0] rtype, logic [15:0] rsize, logic hnull,
			logic [1:0] hcls, logic [7:0] hslot);
			reply_t r;
			int n;
			int slot;
			bit granted;
			bit [3:0] cnt;
			r = '0;
			granted = 0;
			n = active_classes();
			if (rtype == scbpa_pkg::REQ_ALLOC) begin
				if (rsize == 0)
					r.status = scbpa_pkg::STS_ZERO_SIZE;
				else if (n == 0 || rsize > class_bytes[n - 1])
					r.status = scbpa_pkg::STS_TOO_LARGE;
				else begin
					r.status = scbpa_pkg::STS_EXHAUSTED;
					for (int c = 0; c < n; c++) begin
						if (!granted && class_bytes[c] >= rsize &&
							(freed_depth[c] != 0 || fresh_next[c] < usable_blocks(c))) begin
							granted = 1;
							if (freed_depth[c] != 0) begin
								freed_depth[c]--;
								slot = int'(freed_stack[c][freed_depth[c]]);
							end else begin
								slot = fresh_next[c];
								fresh_next[c]++;
							end
							slot = slot % NBLK;
							refs[c][slot] = 4'd1;
							r.status      = scbpa_pkg::STS_OK;
							r.grant_class = 2'(c);
							r.grant_slot  = 8'(slot);
							r.ref_count   = 4'd1;
							have_grant    = 1;
							last_class    = 2'(c);
							last_slot     = 8'(slot);
						end
					end
				end
			end else if (rtype == REQ_UNKNOWN || hnull || hcls >= n ||
				hslot >= usable_blocks(hcls)) begin
				r.status = scbpa_pkg::STS_INVALID;
			end else begin
				cnt = refs[hcls][hslot];
				if (cnt == 0)
					r.status = scbpa_pkg::STS_UNUSED;
				else if (rtype == scbpa_pkg::REQ_FREE) begin
					cnt--;
					refs[hcls][hslot] = cnt;
					if (cnt == 0 && freed_depth[hcls] < NBLK) begin
						freed_stack[hcls][freed_depth[hcls]] = hslot;
						freed_depth[hcls]++;
					end
					r.status    = scbpa_pkg::STS_OK;
					r.ref_count = cnt;
				end else if (cnt >= REF_MAX) begin
					r.status    = scbpa_pkg::STS_LINK_LIMIT;
					r.ref_count = cnt;
				end else begin
					cnt++;
					refs[hcls][hslot] = cnt;
					r.status    = scbpa_pkg::STS_OK;
					r.ref_count = cnt;
				end
			end
			return r;
		endfunction

		function void note_request(logic [1:0] rtype, logic [15:0] rsize, logic hnull,
			logic [1:0] hcls, logic [7:0] hslot);
			awaited.push_back(predict_reply(rtype, rsize, hnull, hcls, hslot));
		endfunction

		function void check_result(logic [2:0] st, logic [1:0] gc, logic [7:0] gs,
			logic [3:0] rc);
			reply_t w;
			if (awaited.size() == 0) begin
				$error("result word with nothing outstanding: status %0d", st);
				mismatches++;
			end else begin
				w = awaited.pop_front();
				if (st !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, st);
					mismatches++;
				end
				if (gc !== w.grant_class) begin
					$error("grant_class: expected %0d, got %0d", w.grant_class, gc);
					mismatches++;
				end
				if (gs !== w.grant_slot) begin
					$error("grant_slot: expected %0d, got %0d", w.grant_slot, gs);
					mismatches++;
				end
				if (rc !== w.ref_count) begin
					$error("ref_count: expected %0d, got %0d", w.ref_count, rc);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [scbpa_pkg::PADDR_W-1:0]  paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           start = 1'b0;
	logic                           busy;
	logic [1:0]                     req_type = '0;
	logic [15:0]                    req_size = '0;
	logic                           handle_null = 1'b0;
	logic [1:0]                     handle_class = '0;
	logic [7:0]                     handle_slot = '0;
	logic                           done;
	logic [2:0]                     status;
	logic [1:0]                     grant_class;
	logic [7:0]                     grant_slot;
	logic [3:0]                     ref_count;

	pool_tracker tracker = new();
	bit          quiet = 0;
	int          idle_cycles = 0;

	size_class_block_pool_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.req_size     (req_size),
		.handle_null  (handle_null),
		.handle_class (handle_class),
		.handle_slot  (handle_slot),
		.done         (done),
		.status       (status),
		.grant_class  (grant_class),
		.grant_slot   (grant_slot),
		.ref_count    (ref_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(status, grant_class, grant_slot, ref_count);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("size_class_block_pool_allocator regression: fail");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] rtype, logic [15:0] rsize, logic hnull,
		logic [1:0] hcls, logic [7:0] hslot);
		int gap;
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type     = rtype;
		req_size     = rsize;
		handle_null  = hnull;
		handle_class = hcls;
		handle_slot  = hslot;
		start        = 1'b1;
		do @(posedge clk); while (busy);
		tracker.note_request(rtype, rsize, hnull, hcls, hslot);
		@(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_reg(idx, val);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic program_pool(logic [63:0] sizes, logic [35:0] counts);
		start = 1'b0;
		while (tracker.awaited.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		for (int i = 0; i < NCLS; i++)
			reg_write(3'(scbpa_pkg::REG_SIZE0 + i), {16'd0, sizes[16*i +: 16]});
		for (int i = 0; i < NCLS; i++)
			reg_write(3'(scbpa_pkg::REG_COUNT0 + i), {23'd0, counts[9*i +: 9]});
	endtask

	task automatic random_phase(int items);
		int n;
		int k;
		int c;
		int burst;
		logic [1:0]  rtype;
		logic [15:0] rsize;
		logic        hnull;
		logic [1:0]  hcls;
		logic [7:0]  hslot;
		burst = 0;
		for (int i = 0; i < items; i++) begin
			n     = tracker.active_classes();
			rsize = 16'($urandom_range(0, 65535));
			hnull = ($urandom_range(0, 19) == 0);
			hcls  = 2'($urandom_range(0, 3));
			hslot = 8'($urandom_range(0, 255));
			k     = $urandom_range(0, 99);
			if (burst == 0 && $urandom_range(0, 49) == 0)
				burst = 16;
			if (burst > 0 && tracker.have_grant) begin
				burst--;
				rtype = scbpa_pkg::REQ_LINK;
				hnull = 1'b0;
				hcls  = tracker.last_class;
				hslot = tracker.last_slot;
			end else if (k < 45) begin
				rtype = scbpa_pkg::REQ_ALLOC;
				k = $urandom_range(0, 19);
				if (k == 0)
					rsize = 16'd0;
				else if (k == 1)
					rsize = 16'hFFFF;
				else if (k < 17 && n > 0) begin
					c = $urandom_range(0, n - 1);
					if (tracker.class_bytes[c] > 0)
						rsize = 16'($urandom_range(1, tracker.class_bytes[c]));
				end
			end else begin
				if (k < 75)
					rtype = scbpa_pkg::REQ_FREE;
				else if (k < 96)
					rtype = scbpa_pkg::REQ_LINK;
				else
					rtype = REQ_UNKNOWN;
				k = $urandom_range(0, 9);
				if (k < 5 && tracker.have_grant) begin
					hcls  = tracker.last_class;
					hslot = tracker.last_slot;
				end else if (k < 8 && tracker.fresh_next[hcls] > 0) begin
					hslot = 8'($urandom_range(0, tracker.fresh_next[hcls] - 1));
				end
			end
			send_request(rtype, rsize, hnull, hcls, hslot);
		end
	endtask

	task automatic random_pool();
		logic [15:0] s[NCLS];
		logic [15:0] t;
		logic [63:0] sizes;
		logic [35:0] counts;
		int k;
		for (int i = 0; i < NCLS; i++) begin
			s[i] = 16'($urandom_range(1, 65535));
			k = $urandom_range(0, 19);
			if (k < 15)
				counts[9*i +: 9] = 9'($urandom_range(1, 8));
			else if (k < 18)
				counts[9*i +: 9] = 9'd256;
			else if (k < 19)
				counts[9*i +: 9] = 9'd0;
			else
				counts[9*i +: 9] = 9'($urandom_range(257, 511));
		end
		if ($urandom_range(0, 4) != 0) begin
			for (int i = 0; i < NCLS - 1; i++)
				for (int j = 0; j < NCLS - 1 - i; j++)
					if (s[j] > s[j + 1]) begin
						t        = s[j];
						s[j]     = s[j + 1];
						s[j + 1] = t;
					end
		end
		sizes = {s[3], s[2], s[1], s[0]};
		program_pool(sizes, counts);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(scbpa_pkg::REQ_ALLOC, 16'd0, 1'b0, 2'd0, 8'd0);
		send_request(scbpa_pkg::REQ_ALLOC, 16'hFFFF, 1'b1, 2'd3, 8'hFF);
		send_request(scbpa_pkg::REQ_ALLOC, 16'd1, 1'b0, 2'd0, 8'd0);
		send_request(scbpa_pkg::REQ_ALLOC, 16'd4096, 1'b0, 2'd0, 8'd0);
		send_request(scbpa_pkg::REQ_FREE, 16'hFFFF, 1'b0, 2'd0, 8'd0);
		send_request(scbpa_pkg::REQ_FREE, 16'd0, 1'b0, 2'd0, 8'd0);
		send_request(scbpa_pkg::REQ_ALLOC, 16'd64, 1'b0, 2'd0, 8'd0);
		send_request(scbpa_pkg::REQ_LINK, 16'd0, 1'b1, 2'd0, 8'd0);
		send_request(REQ_UNKNOWN, 16'd0, 1'b0, 2'd0, 8'd0);
		send_request(scbpa_pkg::REQ_LINK, 16'd0, 1'b0, 2'd3, 8'd255);
		repeat (15) send_request(scbpa_pkg::REQ_LINK, 16'd0, 1'b0, 2'd3, 8'd0);

		program_pool({16'd64, 16'd48, 16'd32, 16'd16}, {9'd4, 9'd4, 9'd4, 9'd4});
		random_phase(130);
		program_pool({16'd100, 16'd100, 16'd100, 16'd0}, {9'd8, 9'd8, 9'd8, 9'd8});
		random_phase(30);
		program_pool({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			{9'd256, 9'd0, 9'd2, 9'd1});
		random_phase(120);
		program_pool({16'hFFFF, 16'hFFFF, 16'd100, 16'd1}, {9'd1, 9'd300, 9'd256, 9'd511});
		random_phase(120);
		program_pool({16'd20, 16'd5000, 16'd10, 16'd1000}, {9'd3, 9'd3, 9'd3, 9'd3});
		random_phase(120);
		for (int p = 0; p < 4; p++) begin
			random_pool();
			random_phase(120);
		end

		start = 1'b0;
		while (tracker.awaited.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("size_class_block_pool_allocator regression: pass");
		else
			$display("size_class_block_pool_allocator regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/scbpa_pkg.sv
rtl/scbpa_regs.sv
rtl/size_class_block_pool_allocator.sv
dv/tb_top.sv
